>>> src/gsp_pkg.sv
// -----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the gaussian grid splat block
// Payload structs, controller commands and status, register indexes and the
// exponential lookup table built at elaboration.
// -----------------------------------------------------------------------------
package gsp_pkg;

   localparam int EXP_TABLE_ENTRIES = 256;
   localparam int EXP_BITS          = 8;
   localparam int EXP_SPAN          = 16;

   localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
   localparam logic [47:0] SAT48       = 48'hFFFF_FFFF_FFFF;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_X  = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_Y  = 2'd2;

   // Divider step counts for each kind of division.
   localparam logic [6:0] DIV_STEPS_NORM = 7'd46;
   localparam logic [6:0] DIV_STEPS_WIN  = 7'd28;
   localparam logic [6:0] DIV_STEPS_IDX  = 7'(EXP_BITS);

   typedef struct packed {
      logic               action;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [23:0]        spread;
      logic [31:0]        amount;
      logic [23:0]        deposit_time;
      logic [7:0]         read_col;
      logic [7:0]         read_row;
   } req_type;

   typedef struct packed {
      logic [47:0] landed_amount;
      logic [47:0] cell_total;
      logic [23:0] cell_first_time;
   } rsp_type;

   typedef struct packed {
      logic [47:0] density;
      logic [23:0] first_time;
   } cell_type;

   typedef enum logic [2:0] {
      DIV_NORM,
      DIV_X0,
      DIV_X1,
      DIV_Y0,
      DIV_Y1,
      DIV_IDX
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_OUT,
      ST_PREP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CELL_INIT,
      ST_FETCH,
      ST_SQUARE,
      ST_SUM,
      ST_IDX_GO,
      ST_IDX_WAIT,
      ST_DEP,
      ST_WRITE,
      ST_AREA,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        clr_wr;
      logic        rd_cell;
      logic        rsp_read;
      logic        prep;
      logic        div_go;
      div_sel_type div_sel;
      logic        div_take;
      logic        cell_init;
      logic        cell_fetch;
      logic        cell_sq;
      logic        cell_sum;
      logic        cell_dep;
      logic        cell_write;
      logic        cell_scale;
      logic        cell_next;
      logic        rsp_dep;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic cell_last;
   } status_type;

   typedef logic [EXP_TABLE_ENTRIES-1:0][31:0] exp_table_type;

   // Q31 table of exp(-i*16/entries), built by repeated multiplication with a
   // ratio taken from a twelve-term Taylor series.
   function automatic exp_table_type build_exp_table();
      logic [63:0]   x;
      logic [63:0]   term;
      logic [63:0]   r;
      longint        sum;
      exp_table_type t;
      x    = (64'(EXP_SPAN) << 31) / 64'(EXP_TABLE_ENTRIES);
      term = 64'd1 << 31;
      sum  = longint'(64'd1 << 31);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * x) >> 31) / 64'(k);
         if ((k % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      r = (sum > 0) ? 64'(sum) : 64'd0;
      t[0] = 32'h8000_0000;
      for (int i = 1; i < EXP_TABLE_ENTRIES; i++) begin
         t[i] = 32'(((64'(t[i-1]) * r) + (64'd1 << 30)) >> 31);
      end
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

>>> src/gsp_ram.sv
// -----------------------------------------------------------------------------
// gsp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module gsp_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/gsp_div.sv
// -----------------------------------------------------------------------------
// gsp_div: shared restoring divider
// One quotient bit per cycle. The dividend is split so that only the last
// "steps" bits are shifted in, which suits divisions with a known small quotient.
// -----------------------------------------------------------------------------
module gsp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   input  logic [6:0]  steps,
   output logic [63:0] quot,
   output logic        rem_nz,
   output logic        done
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] nlow_ff, nlow_in;
   logic [63:0] quot_ff, quot_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;

   assign trial = {rem_ff, nlow_ff[63]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      nlow_in = nlow_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num >> steps;
         nlow_in = num << (7'd64 - steps);
         quot_in = '0;
         den_in  = den;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[63:0] : trial[63:0];
         quot_in = {quot_ff[62:0], ge};
         nlow_in = {nlow_ff[62:0], 1'b0};
         cnt_in  = cnt_ff - 7'd1;
         busy_in = (cnt_ff != 7'd1);
         done_in = (cnt_ff == 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      nlow_ff <= nlow_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign quot   = quot_ff;
   assign rem_nz = (rem_ff != 64'd0);
   assign done   = done_ff;

endmodule

>>> src/gsp_ctrl.sv
// -----------------------------------------------------------------------------
// gsp_ctrl: sequencing controller
// Runs the clearing pass, the read flow and the deposit flow, driving the
// datapath by commands and following its status.
// -----------------------------------------------------------------------------
module gsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                item_is_read,
   input  gsp_pkg::status_type status,
   output gsp_pkg::cmd_type    cmd,
   output logic                busy
);

   gsp_pkg::state_type   state_ff, state_in;
   gsp_pkg::div_sel_type sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         gsp_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = gsp_pkg::ST_IDLE;
         end
         gsp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = item_is_read ? gsp_pkg::ST_RD_ISSUE : gsp_pkg::ST_PREP;
            end
         end
         gsp_pkg::ST_RD_ISSUE: state_in = gsp_pkg::ST_RD_OUT;
         gsp_pkg::ST_RD_OUT:   state_in = gsp_pkg::ST_IDLE;
         gsp_pkg::ST_PREP: begin
            sel_in   = gsp_pkg::DIV_NORM;
            state_in = gsp_pkg::ST_DIV_GO;
         end
         gsp_pkg::ST_DIV_GO:   state_in = gsp_pkg::ST_DIV_WAIT;
         gsp_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               unique case (sel_ff)
                  gsp_pkg::DIV_NORM: sel_in = gsp_pkg::DIV_X0;
                  gsp_pkg::DIV_X0:   sel_in = gsp_pkg::DIV_X1;
                  gsp_pkg::DIV_X1:   sel_in = gsp_pkg::DIV_Y0;
                  gsp_pkg::DIV_Y0:   sel_in = gsp_pkg::DIV_Y1;
                  default:           sel_in = gsp_pkg::DIV_NORM;
               endcase
               state_in = (sel_ff == gsp_pkg::DIV_Y1) ? gsp_pkg::ST_CELL_INIT
                                                      : gsp_pkg::ST_DIV_GO;
            end
         end
         gsp_pkg::ST_CELL_INIT: state_in = gsp_pkg::ST_FETCH;
         gsp_pkg::ST_FETCH:     state_in = gsp_pkg::ST_SQUARE;
         gsp_pkg::ST_SQUARE:    state_in = gsp_pkg::ST_SUM;
         gsp_pkg::ST_SUM:       state_in = gsp_pkg::ST_IDX_GO;
         gsp_pkg::ST_IDX_GO:    state_in = gsp_pkg::ST_IDX_WAIT;
         gsp_pkg::ST_IDX_WAIT: begin
            if (status.div_done) state_in = gsp_pkg::ST_DEP;
         end
         gsp_pkg::ST_DEP:   state_in = gsp_pkg::ST_WRITE;
         gsp_pkg::ST_WRITE: state_in = gsp_pkg::ST_AREA;
         gsp_pkg::ST_AREA:  state_in = gsp_pkg::ST_NEXT;
         gsp_pkg::ST_NEXT: begin
            state_in = status.cell_last ? gsp_pkg::ST_DONE : gsp_pkg::ST_FETCH;
         end
         gsp_pkg::ST_DONE: state_in = gsp_pkg::ST_IDLE;
         default:          state_in = gsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == gsp_pkg::ST_IDLE) && accept;
      cmd.clr_wr     = (state_ff == gsp_pkg::ST_CLEAR);
      cmd.rd_cell    = (state_ff == gsp_pkg::ST_RD_ISSUE);
      cmd.rsp_read   = (state_ff == gsp_pkg::ST_RD_OUT);
      cmd.prep       = (state_ff == gsp_pkg::ST_PREP);
      cmd.div_go     = (state_ff == gsp_pkg::ST_DIV_GO) || (state_ff == gsp_pkg::ST_IDX_GO);
      cmd.div_sel    = ((state_ff == gsp_pkg::ST_IDX_GO) || (state_ff == gsp_pkg::ST_IDX_WAIT))
                       ? gsp_pkg::DIV_IDX : sel_ff;
      cmd.div_take   = ((state_ff == gsp_pkg::ST_DIV_WAIT) || (state_ff == gsp_pkg::ST_IDX_WAIT))
                       && status.div_done;
      cmd.cell_init  = (state_ff == gsp_pkg::ST_CELL_INIT);
      cmd.cell_fetch = (state_ff == gsp_pkg::ST_FETCH);
      cmd.cell_sq    = (state_ff == gsp_pkg::ST_SQUARE);
      cmd.cell_sum   = (state_ff == gsp_pkg::ST_SUM);
      cmd.cell_dep   = (state_ff == gsp_pkg::ST_DEP);
      cmd.cell_write = (state_ff == gsp_pkg::ST_WRITE);
      cmd.cell_scale = (state_ff == gsp_pkg::ST_AREA);
      cmd.cell_next  = (state_ff == gsp_pkg::ST_NEXT);
      cmd.rsp_dep    = (state_ff == gsp_pkg::ST_DONE);
      busy           = (state_ff != gsp_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsp_pkg::ST_CLEAR;
         sel_ff   <= gsp_pkg::DIV_NORM;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

>>> src/gsp_datapath.sv
// -----------------------------------------------------------------------------
// gsp_datapath: arithmetic, configuration and grid store
// Holds the item, the window, the per-cell arithmetic, the shared divider and
// the cell store, and registers the result.
// -----------------------------------------------------------------------------
module gsp_datapath #(
   parameter int GRID_SIZE = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  gsp_pkg::cmd_type    cmd,
   output gsp_pkg::status_type status,
   input  gsp_pkg::req_type    req_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_strobe,
   output gsp_pkg::rsp_type    rsp_data
);

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(GRID_SIZE);
   localparam int CAW   = $clog2(CELLS);
   localparam int CW    = $bits(gsp_pkg::cell_type);

   // Configuration.
   logic [15:0] cell_size_ff;
   logic [7:0]  origin_x_ff;
   logic [7:0]  origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= 16'd256;
         origin_x_ff  <= 8'd128;
         origin_y_ff  <= 8'd128;
      end else if (csr_we) begin
         case (csr_index)
            gsp_pkg::CSR_CELL_SIZE: cell_size_ff <= csr_wdata;
            gsp_pkg::CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata[7:0];
            gsp_pkg::CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [15:0] c_eff;
   assign c_eff = (cell_size_ff == 16'd0) ? 16'd1 : cell_size_ff;

   // Captured item and per-deposit constants.
   gsp_pkg::req_type req_ff;
   logic [23:0]      s_eff;
   logic [47:0]      s2_ff, s2_in;
   logic [61:0]      prod_ff, prod_in;

   assign s_eff = (req_ff.spread == 24'd0) ? 24'd1 : req_ff.spread;
   assign s2_in   = {24'd0, s_eff} * {24'd0, s_eff};
   assign prod_in = {30'd0, req_ff.amount} * {32'd0, gsp_pkg::INV_2PI_Q32};

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.prep) begin
         s2_ff   <= s2_in;
         prod_ff <= prod_in;
      end
   end

   // Exponent scale: D = 32*s^2, brought below 2^51 by at most two shifts.
   logic [52:0] dfull;
   logic [1:0]  dshift;
   logic [50:0] dsh;
   assign dfull  = {s2_ff, 5'd0};
   assign dshift = dfull[52] ? 2'd2 : (dfull[51] ? 2'd1 : 2'd0);
   assign dsh    = 51'(dfull >> dshift);

   // Window edges before division: 2x-7s and 2x+7s.
   logic signed [31:0] px, py, s7, ax_lo, ax_hi, ay_lo, ay_hi, a_cur, a_mag;
   assign px    = {{8{req_ff.pos_x[23]}}, req_ff.pos_x};
   assign py    = {{8{req_ff.pos_y[23]}}, req_ff.pos_y};
   assign s7    = signed'({8'd0, s_eff}) * 32'sd7;
   assign ax_lo = (px <<< 1) - s7;
   assign ax_hi = (px <<< 1) + s7;
   assign ay_lo = (py <<< 1) - s7;
   assign ay_hi = (py <<< 1) + s7;

   // Divider operands.
   logic [63:0] div_num, div_den, div_quot;
   logic [6:0]  div_steps;
   logic        div_nz, div_done;
   logic [58:0] d2_ff, d2_in, d2sh;
   assign d2sh = d2_ff >> dshift;

   always_comb begin
      unique case (cmd.div_sel)
         gsp_pkg::DIV_X0: a_cur = ax_lo;
         gsp_pkg::DIV_X1: a_cur = ax_hi;
         gsp_pkg::DIV_Y0: a_cur = ay_lo;
         default:         a_cur = ay_hi;
      endcase
      a_mag = (a_cur < 0) ? -a_cur : a_cur;
      unique case (cmd.div_sel)
         gsp_pkg::DIV_NORM: begin
            div_num   = {18'd0, prod_ff[61:16]};
            div_den   = {16'd0, s2_ff};
            div_steps = gsp_pkg::DIV_STEPS_NORM;
         end
         gsp_pkg::DIV_IDX: begin
            div_num   = 64'({5'd0, d2sh} << gsp_pkg::EXP_BITS);
            div_den   = {13'd0, dsh};
            div_steps = gsp_pkg::DIV_STEPS_IDX;
         end
         default: begin
            div_num   = {36'd0, a_mag[27:0]};
            div_den   = {47'd0, c_eff, 1'b0};
            div_steps = gsp_pkg::DIV_STEPS_WIN;
         end
      endcase
   end

   gsp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_go),
      .num    (div_num),
      .den    (div_den),
      .steps  (div_steps),
      .quot   (div_quot),
      .rem_nz (div_nz),
      .done   (div_done)
   );

   // Floor for the low edge, ceiling for the high edge, then origin and clamp.
   logic signed [31:0] qv, edge_v, edge_w;
   logic [AW-1:0]      edge_c;
   logic               is_lo;
   logic [7:0]         org_cur;

   always_comb begin
      qv      = signed'({2'd0, div_quot[29:0]});
      is_lo   = (cmd.div_sel == gsp_pkg::DIV_X0) || (cmd.div_sel == gsp_pkg::DIV_Y0);
      org_cur = ((cmd.div_sel == gsp_pkg::DIV_X0) || (cmd.div_sel == gsp_pkg::DIV_X1))
                ? origin_x_ff : origin_y_ff;
      if (is_lo) begin
         edge_v = (a_cur < 0) ? -(qv + 32'(div_nz)) : qv;
      end else begin
         edge_v = (a_cur > 0) ? (qv + 32'(div_nz)) : -qv;
      end
      edge_w = edge_v + signed'({24'd0, org_cur});
      if (edge_w < 0) begin
         edge_c = '0;
      end else if (edge_w > 32'(GRID_SIZE - 1)) begin
         edge_c = AW'(GRID_SIZE - 1);
      end else begin
         edge_c = edge_w[AW-1:0];
      end
   end

   logic [45:0]                 norm_ff;
   logic [gsp_pkg::EXP_BITS-1:0] idx_ff;
   logic [AW-1:0]               gx0_ff, gx1_ff, gy0_ff, gy1_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_take) begin
         unique case (cmd.div_sel)
            gsp_pkg::DIV_NORM: norm_ff <= div_quot[45:0];
            gsp_pkg::DIV_X0:   gx0_ff  <= edge_c;
            gsp_pkg::DIV_X1:   gx1_ff  <= edge_c;
            gsp_pkg::DIV_Y0:   gy0_ff  <= edge_c;
            gsp_pkg::DIV_Y1:   gy1_ff  <= edge_c;
            default:           idx_ff  <= div_quot[gsp_pkg::EXP_BITS-1:0];
         endcase
      end
   end

   // Per-cell walk.
   logic [AW-1:0]      gx_ff, gy_ff;
   logic [CAW-1:0]     cell_addr;
   logic signed [31:0] rx, ry;
   logic [28:0]        adx_ff, ady_ff, adx_in, ady_in;
   logic [57:0]        sqx_ff, sqy_ff;
   logic               inrng_ff, inrng_in;
   logic [46:0]        dep_ff, dep_in;
   logic [54:0]        t1_ff;
   logic [47:0]        area_ff, area_in;
   logic [47:0]        landed_ff, landed_in;
   logic [31:0]        e_val;
   logic [62:0]        dprod, t1prod;
   logic [70:0]        aprod;
   logic [48:0]        nd, lsum;
   gsp_pkg::cell_type  old_cell, new_cell;

   assign cell_addr = CAW'(32'(gy_ff) * GRID_SIZE + 32'(gx_ff));

   always_comb begin
      rx     = (signed'(32'(gx_ff)) - signed'({24'd0, origin_x_ff}))
               * signed'({16'd0, c_eff}) - px;
      ry     = (signed'(32'(gy_ff)) - signed'({24'd0, origin_y_ff}))
               * signed'({16'd0, c_eff}) - py;
      adx_in = (rx < 0) ? 29'(-rx) : 29'(rx);
      ady_in = (ry < 0) ? 29'(-ry) : 29'(ry);
      d2_in    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      inrng_in = {1'b0, d2_in} < {7'd0, dfull};
      e_val    = inrng_ff ? gsp_pkg::EXP_TABLE[idx_ff] : 32'd0;
      dprod    = {17'd0, norm_ff} * {46'd0, e_val[31:15]};
      dep_in   = dprod[62:16];
      nd       = {1'b0, old_cell.density} + {2'd0, dep_ff};
      new_cell.density    = nd[48] ? gsp_pkg::SAT48 : nd[47:0];
      new_cell.first_time = old_cell.first_time;
      if ((dep_ff != 47'd0) && ((old_cell.first_time == 24'd0)
                                || (req_ff.deposit_time < old_cell.first_time))) begin
         new_cell.first_time = req_ff.deposit_time;
      end
      t1prod  = {16'd0, dep_ff} * {47'd0, c_eff};
      aprod   = {16'd0, t1_ff} * {55'd0, c_eff};
      area_in = (aprod[70:56] != 15'd0) ? gsp_pkg::SAT48 : aprod[55:8];
      lsum    = {1'b0, landed_ff} + {1'b0, area_ff};
      landed_in = lsum[48] ? gsp_pkg::SAT48 : lsum[47:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_init) begin
         gx_ff     <= gx0_ff;
         gy_ff     <= gy0_ff;
         landed_ff <= '0;
      end
      if (cmd.cell_fetch) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
      end
      if (cmd.cell_sq) begin
         sqx_ff <= {29'd0, adx_ff} * {29'd0, adx_ff};
         sqy_ff <= {29'd0, ady_ff} * {29'd0, ady_ff};
      end
      if (cmd.cell_sum) begin
         d2_ff    <= d2_in;
         inrng_ff <= inrng_in;
      end
      if (cmd.cell_dep) dep_ff <= dep_in;
      if (cmd.cell_write) t1_ff <= t1prod[62:8];
      if (cmd.cell_scale) area_ff <= area_in;
      if (cmd.cell_next) begin
         landed_ff <= landed_in;
         if (gx_ff == gx1_ff) begin
            gx_ff <= gx0_ff;
            gy_ff <= gy_ff + AW'(1);
         end else begin
            gx_ff <= gx_ff + AW'(1);
         end
      end
   end

   // Clearing pass after reset.
   logic [CAW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + CAW'(1);
      end
   end

   // Cell store.
   logic           read_inside_ff;
   logic [CAW-1:0] read_addr;
   logic [CW-1:0]  ram_rdata, ram_wdata;
   logic [CAW-1:0] ram_waddr, ram_raddr;
   logic           ram_we, ram_re;

   assign read_addr = CAW'(32'(req_ff.read_row) * GRID_SIZE + 32'(req_ff.read_col));
   assign old_cell  = ram_rdata;
   assign ram_we    = cmd.clr_wr | cmd.cell_write;
   assign ram_waddr = cmd.clr_wr ? clr_ff : cell_addr;
   assign ram_wdata = cmd.clr_wr ? '0 : new_cell;
   assign ram_re    = cmd.rd_cell | cmd.cell_fetch;
   assign ram_raddr = cmd.rd_cell ? read_addr : cell_addr;

   always_ff @(posedge clock) begin
      if (cmd.rd_cell) begin
         read_inside_ff <= (32'(req_ff.read_col) < GRID_SIZE)
                           && (32'(req_ff.read_row) < GRID_SIZE);
      end
   end

   gsp_ram #(
      .WIDTH (CW),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Result register.
   logic             rsp_strobe_ff;
   gsp_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_read | cmd.rsp_dep;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_read) begin
         rsp_data_ff.landed_amount   <= '0;
         rsp_data_ff.cell_total      <= read_inside_ff ? old_cell.density : 48'd0;
         rsp_data_ff.cell_first_time <= read_inside_ff ? old_cell.first_time : 24'd0;
      end else if (cmd.rsp_dep) begin
         rsp_data_ff.landed_amount   <= landed_ff;
         rsp_data_ff.cell_total      <= '0;
         rsp_data_ff.cell_first_time <= '0;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.clr_last  = (clr_ff == CAW'(CELLS - 1));
   assign status.div_done  = div_done;
   assign status.cell_last = (gx_ff == gx1_ff) && (gy_ff == gy1_ff);

endmodule

>>> src/gaussian_grid_splat_top.sv
// -----------------------------------------------------------------------------
// gaussian_grid_splat_top: gaussian splat onto a square accumulation grid
// Deposits a weighted point as a 2-D gaussian over a window of grid cells and
// reads back single cells.
// -----------------------------------------------------------------------------
// An item is taken on a rising edge where start is high and busy is low, and
// its one result appears on rsp_data for exactly one cycle with rsp_strobe
// high; the receiver cannot hold results off, so it must take every strobe.
// After reset the block first clears its cell store, one cell per cycle, all
// GRID_SIZE*GRID_SIZE cells (65536 at the default size); busy stays high
// throughout, though configuration writes are taken at any time. A read item
// passes through an issue state and an output state, and its result strobe is
// registered after the output state. A deposit is set up by five divisions on
// one shared radix-2 divider (46 steps for the normalisation, 28 for each
// window edge), and then walks its clamped window one cell at a time: each cell
// takes one read-modify-write of the cell store and an 8-step division that
// finds the exponential table index.
// Configuration should be written only while the block is idle.
module gaussian_grid_splat_top #(
   parameter int GRID_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gsp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gsp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   gsp_pkg::cmd_type    cmd;
   gsp_pkg::status_type status;
   logic                accept;

   // An item is accepted only while the controller sits idle.
   assign accept = start & ~busy;

   // The controller sequences each item; the datapath carries out its steps.
   gsp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item_is_read (req_data.action),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   gsp_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: self-checking bench for the gaussian grid splat block
// Drives deposit and read items through the start/busy command port, predicts
// every result with a bit-accurate software copy of the grid, and compares
// each strobed result field by field, across several register settings.
// -----------------------------------------------------------------------------
module tb;

   localparam int          GRID        = 256;
   localparam int          TABLE_LEN   = 256;
   localparam int          REQ_W       = $bits(gsp_pkg::req_type);
   localparam longint      CYCLE_LIMIT = 20_000_000;
   localparam logic        ACT_DEPOSIT = 1'b0;
   localparam logic        ACT_READ    = 1'b1;
   localparam logic [63:0] SAT         = 64'hFFFF_FFFF_FFFF;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   gsp_pkg::req_type req_data;
   logic             rsp_strobe;
   gsp_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [15:0]      csr_wdata;

   // Software copy of the grid and of the registers.
   logic [47:0] density_mem [0:GRID*GRID-1];
   logic [23:0] first_mem   [0:GRID*GRID-1];
   logic [31:0] exp_lut     [0:TABLE_LEN-1];
   logic [15:0] cur_cell_size;
   logic [7:0]  cur_origin_x;
   logic [7:0]  cur_origin_y;

   gsp_pkg::rsp_type pending_results[$];
   int               errors;
   longint           cycles;
   int               last_col;
   int               last_row;

   gaussian_grid_splat_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is stopped here if the block ever hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Exponential table: the decay ratio comes from a twelve-term series, and
   // each entry is the previous one times the ratio, rounded.
   task automatic fill_exp_lut();
      logic [63:0] step;
      logic [63:0] term;
      logic [63:0] ratio;
      longint      acc;
      step = (64'd16 << 31) / 64'(TABLE_LEN);
      term = 64'd1 << 31;
      acc  = longint'(64'd1 << 31);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * step) >> 31) / 64'(k);
         acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      ratio = (acc > 0) ? 64'(acc) : 64'd0;
      exp_lut[0] = 32'h8000_0000;
      for (int i = 1; i < TABLE_LEN; i++)
         exp_lut[i] = 32'(((64'(exp_lut[i-1]) * ratio) + (64'd1 << 30)) >> 31);
   endtask

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint ceil_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a > 0) q = q + 1;
      return q;
   endfunction

   function automatic longint to_grid(longint v);
      return (v < 0) ? 0 : ((v > GRID - 1) ? GRID - 1 : v);
   endfunction

   // Applies one accepted item to the grid copy and returns its result.
   function automatic gsp_pkg::rsp_type splat_predict(gsp_pkg::req_type it);
      gsp_pkg::rsp_type r;
      longint      px, py, sg, cs, ox, oy, c0, c1, r0, r1, ddx, ddy;
      logic [63:0] s2, dlim, dsh, norm, d2, e, dep, nd, t1, area, landed, tidx;
      int          shift, ci;
      r = '0;
      if (it.action == ACT_READ) begin
         ci = {it.read_row, it.read_col};
         r.cell_total      = density_mem[ci];
         r.cell_first_time = first_mem[ci];
         return r;
      end
      px = longint'(it.pos_x);
      py = longint'(it.pos_y);
      sg = (it.spread == 0) ? 1 : longint'(it.spread);
      cs = (cur_cell_size == 0) ? 1 : longint'(cur_cell_size);
      ox = longint'(cur_origin_x);
      oy = longint'(cur_origin_y);
      c0 = to_grid(floor_div(2 * px - 7 * sg, 2 * cs) + ox);
      c1 = to_grid(ceil_div(2 * px + 7 * sg, 2 * cs) + ox);
      r0 = to_grid(floor_div(2 * py - 7 * sg, 2 * cs) + oy);
      r1 = to_grid(ceil_div(2 * py + 7 * sg, 2 * cs) + oy);
      s2   = 64'(sg) * 64'(sg);
      dlim = 32 * s2;
      norm = ((64'(it.amount) * 64'd683565276) >> 16) / s2;
      dsh  = dlim;
      shift = 0;
      while (dsh >= (64'd1 << 51)) begin
         dsh = dsh >> 1;
         shift++;
      end
      landed = 0;
      for (longint gy = r0; gy <= r1; gy++) begin
         ddy = (gy - oy) * cs - py;
         if (ddy < 0) ddy = -ddy;
         for (longint gx = c0; gx <= c1; gx++) begin
            ddx = (gx - ox) * cs - px;
            if (ddx < 0) ddx = -ddx;
            d2 = 64'(ddx) * 64'(ddx) + 64'(ddy) * 64'(ddy);
            e  = 0;
            if (d2 < dlim) begin
               tidx = ((d2 >> shift) * 64'(TABLE_LEN)) / dsh;
               if (tidx < 64'(TABLE_LEN)) e = 64'(exp_lut[tidx]);
            end
            dep = (norm * (e >> 15)) >> 16;
            ci  = int'(gy) * GRID + int'(gx);
            nd  = 64'(density_mem[ci]) + dep;
            density_mem[ci] = (nd > SAT) ? SAT[47:0] : nd[47:0];
            if (dep > 0 && (first_mem[ci] == 0 || it.deposit_time < first_mem[ci]))
               first_mem[ci] = it.deposit_time;
            t1 = (dep * 64'(cs)) >> 8;
            if (t1 > 64'hFFFF_FFFF_FFFF_FFFF / 64'(cs)) begin
               area = SAT;
            end else begin
               area = (t1 * 64'(cs)) >> 8;
               if (area > SAT) area = SAT;
            end
            landed = landed + area;
            if (landed > SAT) landed = SAT;
         end
      end
      r.landed_amount = landed[47:0];
      return r;
   endfunction

   // Every strobe is a result the block insists on handing over this cycle.
   always @(posedge clock) begin
      gsp_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: nothing outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.landed_amount !== want.landed_amount) begin
               $error("landed_amount expected %0d actual %0d",
                      want.landed_amount, rsp_data.landed_amount);
               errors++;
            end
            if (rsp_data.cell_total !== want.cell_total) begin
               $error("cell_total expected %0d actual %0d",
                      want.cell_total, rsp_data.cell_total);
               errors++;
            end
            if (rsp_data.cell_first_time !== want.cell_first_time) begin
               $error("cell_first_time expected %0d actual %0d",
                      want.cell_first_time, rsp_data.cell_first_time);
               errors++;
            end
         end
      end
   end

   // Offers one item after a random gap. The start line is left high on
   // return so that a back-to-back item never sees it dropped and raised in
   // the same step; whoever idles next lowers it.
   task automatic send_item(gsp_pkg::req_type it);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(splat_predict(it));
   endtask

   // Holds off until every outstanding result has come back and the block
   // has settled.
   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // The enable is lowered once the write has been clocked and is still low when
   // the task returns, so that writes in a row never drive it twice at once.
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gsp_pkg::CSR_CELL_SIZE: cur_cell_size = val;
         gsp_pkg::CSR_ORIGIN_X:  cur_origin_x  = val[7:0];
         gsp_pkg::CSR_ORIGIN_Y:  cur_origin_y  = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_grid(logic [15:0] cs, logic [7:0] ox, logic [7:0] oy);
      drain();
      write_reg(gsp_pkg::CSR_CELL_SIZE, cs);
      write_reg(gsp_pkg::CSR_ORIGIN_X, {8'd0, ox});
      write_reg(gsp_pkg::CSR_ORIGIN_Y, {8'd0, oy});
   endtask

   function automatic gsp_pkg::req_type deposit_item(longint x, longint y, int unsigned sg,
                                                     logic [31:0] amt, logic [23:0] t);
      gsp_pkg::req_type it;
      it              = '0;
      it.action       = ACT_DEPOSIT;
      it.pos_x        = 24'(x);
      it.pos_y        = 24'(y);
      it.spread       = 24'(sg);
      it.amount       = amt;
      it.deposit_time = t;
      return it;
   endfunction

   function automatic gsp_pkg::req_type read_item(int col, int row);
      gsp_pkg::req_type it;
      it          = '0;
      it.action   = ACT_READ;
      it.read_col = 8'(col);
      it.read_row = 8'(row);
      return it;
   endfunction

   // Default registers: centre deposits, earliest-time rules, zero spread,
   // the extreme positions and one deposit whose window is the whole grid.
   task automatic test_default_grid();
      send_item(deposit_item(0, 0, 256, 32'd1000000, 24'd500));
      send_item(read_item(128, 128));
      send_item(deposit_item(0, 0, 256, 32'd1000000, 24'd900));
      send_item(deposit_item(0, 0, 256, 32'd1000000, 24'd100));
      send_item(read_item(128, 128));
      send_item(read_item(129, 127));
      // Zero spread behaves as the smallest spread; zero time reads as none.
      send_item(deposit_item(2560, -2560, 0, 32'hFFFF_FFFF, 24'd0));
      send_item(read_item(138, 118));
      send_item(deposit_item(300, 300, 100, 32'd0, 24'hFF_FFFF));
      // Far off the grid: the clamped corner cells are still visited.
      send_item(deposit_item(-8388608, 8388607, 200, 32'd5000, 24'd7));
      send_item(deposit_item(8388607, -8388608, 200, 32'd5000, 24'd7));
      send_item(read_item(0, 255));
      send_item(read_item(255, 0));
      send_item(read_item(255, 255));
      // Widest spread: the window is the whole grid, so this one is slow.
      send_item(deposit_item(0, 0, 24'hFF_FFFF, 32'hFFFF_FFFF, 24'd3));
      send_item(read_item(0, 0));
   endtask

   // Smallest cells and the lowest origin.
   task automatic test_fine_grid();
      set_grid(16'd1, 8'd0, 8'd0);
      send_item(deposit_item(10, 20, 1, 32'd77777, 24'd40));
      send_item(read_item(10, 20));
   endtask

   // Largest cells and origin; repeated peak deposits drive the density and
   // the landed sum into saturation.
   task automatic test_coarse_grid();
      set_grid(16'hFFFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 9; i++)
         send_item(deposit_item(0, 0, 0, 32'hFFFF_FFFF, 24'(20 - i)));
      send_item(read_item(255, 255));
   endtask

   // A cell size of zero is taken as one.
   task automatic test_zero_cell();
      set_grid(16'd0, 8'd128, 8'd128);
      send_item(deposit_item(-3, 4, 1, 32'd123456, 24'd9));
      send_item(read_item(125, 132));
   endtask

   // Mostly well-formed deposits around the grid with reads that follow them,
   // plus off-grid noise; registers change every hundred items.
   task automatic test_random_traffic();
      gsp_pkg::req_type it;
      longint      cs, x, y;
      int          col, row;
      for (int n = 0; n < 520; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 3))
               0: set_grid(16'($urandom_range(1, 65535)), 8'($urandom), 8'($urandom));
               1: set_grid(16'($urandom_range(1, 300)), 8'($urandom), 8'($urandom));
               2: set_grid(16'd256, 8'd128, 8'd128);
               default: set_grid(16'hFFFF, 8'($urandom), 8'($urandom));
            endcase
            // One pause in mid-phase until every result is back.
            if (n == 300) drain();
         end
         cs = (cur_cell_size == 0) ? 1 : longint'(cur_cell_size);
         if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 9) < 8) begin
               col = $urandom_range(0, GRID - 1);
               row = $urandom_range(0, GRID - 1);
               x = (col - longint'(cur_origin_x)) * cs + $urandom_range(0, cs) - cs / 2;
               y = (row - longint'(cur_origin_y)) * cs + $urandom_range(0, cs) - cs / 2;
               last_col = col;
               last_row = row;
            end else begin
               x = longint'($signed(24'($urandom)));
               y = longint'($signed(24'($urandom)));
            end
            it = deposit_item(x, y, $urandom_range(0, cs), $urandom, 24'($urandom));
         end else begin
            // Reads carry random junk in every other field.
            it = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
            it.action = ACT_READ;
            if ($urandom_range(0, 1) == 1) begin
               it.read_col = 8'(last_col + $urandom_range(0, 2) - 1);
               it.read_row = 8'(last_row + $urandom_range(0, 2) - 1);
            end
         end
         send_item(it);
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = gsp_pkg::CSR_CELL_SIZE;
      csr_wdata = '0;
      errors    = 0;
      cycles    = 0;
      last_col  = 128;
      last_row  = 128;
      cur_cell_size = 16'd256;
      cur_origin_x  = 8'd128;
      cur_origin_y  = 8'd128;
      for (int i = 0; i < GRID * GRID; i++) begin
         density_mem[i] = '0;
         first_mem[i]   = '0;
      end
      fill_exp_lut();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_grid();
      test_fine_grid();
      test_coarse_grid();
      test_zero_cell();
      test_random_traffic();

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
